>>> src/mp3sf_pkg.sv
`default_nettype none
package mp3sf_pkg;

   localparam int unsigned COUNT_W  = 29;
   localparam int unsigned SIZE_W   = 28;
   localparam int unsigned LIMIT_W  = 25;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd262144;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_3    = 8'h33;

   // index of the first byte after the fixed tag header
   localparam logic [COUNT_W-1:0] TAG_HDR_LEN = 29'd10;

   typedef enum logic [1:0] {
      STATUS_SEARCHING = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NO_SYNC   = 2'd2
   } status_type;

   // one input beat as held in the input register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } beat_type;

   // frame header check on the first three bytes of a window
   function automatic logic header_ok(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2);
      logic ok;
      begin
         ok = 1'b1;
         if (b0 != SYNC_BYTE) ok = 1'b0;
         if (b1[7:5] != 3'b111) ok = 1'b0;
         if (b1[4:3] == 2'b01) ok = 1'b0;
         if (b1[2:1] != 2'b01) ok = 1'b0;
         if (b2[7:4] == 4'hF) ok = 1'b0;
         if (b2[3:2] == 2'b11) ok = 1'b0;
         return ok;
      end
   endfunction

endpackage
`default_nettype wire

>>> src/mp3sf_in_stage.sv
`default_nettype none
module mp3sf_in_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,   // [7:0] data_byte
   input  wire                  req_tlast,   // end_of_stream
   output logic                 beat_valid,
   input  wire                  beat_ready,
   output mp3sf_pkg::beat_type  beat
);
   import mp3sf_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff, beat_in;

   // register takes a beat when empty or when its content moves on
   assign req_tready = !valid_ff || beat_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         beat_in.data_byte     = req_tdata;
         beat_in.end_of_stream = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule
`default_nettype wire

>>> src/mp3sf_core.sv
`default_nettype none
module mp3sf_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_valid,
   input  wire  [mp3sf_pkg::LIMIT_W-1:0] csr_data,
   input  wire                          beat_valid,
   output logic                         beat_ready,
   input  wire  mp3sf_pkg::beat_type    beat,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [31:0]                  rsp_tdata
);
   import mp3sf_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [23:0]        recent_ff, recent_in;
   logic               tag_ff, tag_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] offset_ff, offset_in;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   logic [7:0]         b0, b1, b2, cur;
   logic [COUNT_W:0]   len;
   logic [COUNT_W:0]   tag_end;
   logic               window;
   logic               found;
   logic [COUNT_W-1:0] off;
   logic               fire;

   assign beat_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = beat_valid && beat_ready;

   assign cur     = beat.data_byte;
   assign b0      = recent_ff[23:16];
   assign b1      = recent_ff[15:8];
   assign b2      = recent_ff[7:0];
   assign len     = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign tag_end = {1'b0, TAG_HDR_LEN} + {2'b00, size_in};
   assign window  = (count_ff >= 29'd3) && header_ok(b0, b1, b2);

   // tag prefix and syncsafe size assembly
   always_comb begin
      tag_in  = tag_ff;
      size_in = size_ff;
      if (count_ff == 29'd2 && b1 == CHAR_I && b2 == CHAR_D && cur == CHAR_3) begin
         tag_in = 1'b1;
      end
      if (count_ff >= 29'd6 && count_ff <= 29'd9) begin
         size_in = {size_ff[SIZE_W-8:0], cur[6:0]};
      end
   end

   // payload search, tag end wins over a header window
   always_comb begin
      found = 1'b0;
      off   = '0;
      priority if (tag_in && len >= 30'd10) begin
         if (len >= tag_end) begin
            found = 1'b1;
            off   = tag_end[COUNT_W-1:0];
         end else if (count_ff >= 29'd13 && window) begin
            found = 1'b1;
            off   = count_ff - 29'd3;
         end
      end else if (window) begin
         found = 1'b1;
         off   = count_ff - 29'd3;
      end else begin
         found = 1'b0;
      end
   end

   // sticky status and offset
   always_comb begin
      status_in = status_ff;
      offset_in = offset_ff;
      if (status_ff == STATUS_SEARCHING) begin
         priority if (found) begin
            status_in = STATUS_FOUND;
            offset_in = off;
         end else if (beat.end_of_stream || len > {5'd0, limit_ff}) begin
            status_in = STATUS_NO_SYNC;
         end else begin
            status_in = STATUS_SEARCHING;
         end
      end
   end

   // history shift and saturating byte count
   always_comb begin
      recent_in = {recent_ff[15:0], cur};
      count_in  = (count_ff == {COUNT_W{1'b1}}) ? count_ff : count_ff + 29'd1;
   end

   // result word: sync_status, payload_offset, tag_detected
   always_comb begin
      rsp_data_in[1:0]  = status_in;
      rsp_data_in[30:2] = (status_in == STATUS_FOUND) ? offset_in : '0;
      rsp_data_in[31]   = tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         recent_ff    <= '0;
         tag_ff       <= 1'b0;
         size_ff      <= '0;
         status_ff    <= STATUS_SEARCHING;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (fire) begin
            count_ff  <= count_in;
            recent_ff <= recent_in;
            tag_ff    <= tag_in;
            size_ff   <= size_in;
            status_ff <= status_in;
            offset_ff <= offset_in;
         end
         if (beat_ready) begin
            rsp_valid_ff <= beat_valid;
         end
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

>>> src/mp3_sync_and_id3_skip_finder.sv
`default_nettype none
// a byte passes through the input register and then the result register before
// its result beat can be taken
// throughput: one byte per cycle unless rsp_tready stalls, set by the register pair
// each input beat yields exactly one result beat carrying the current status
// reset: synchronous, active high; clears counters, history, status and the
// byte limit back to 262144; the configuration port is always ready
module mp3_sync_and_id3_skip_finder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] sync_status, [30:2] payload_offset,
                                    // [31] tag_detected
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [24:0] csr_data     // [24:0] give_up_bytes
);
   import mp3sf_pkg::*;

   logic     beat_valid;
   logic     beat_ready;
   beat_type beat;

   assign csr_ready = 1'b1;

   mp3sf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat)
   );

   mp3sf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> src/mp3sf_checker.sv
`default_nettype none
module mp3sf_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);
   import mp3sf_pkg::*;

   logic       final_ff;
   logic [1:0] last_status_ff;
   logic       rsp_beat;

   assign rsp_beat = rsp_tvalid && rsp_tready;

   // remember a final status once it has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         final_ff       <= 1'b0;
         last_status_ff <= STATUS_SEARCHING;
      end else if (rsp_beat && !final_ff && rsp_tdata[1:0] != STATUS_SEARCHING) begin
         final_ff       <= 1'b1;
         last_status_ff <= rsp_tdata[1:0];
      end
   end

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // offset is zero unless the payload was found
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_FOUND |-> rsp_tdata[30:2] == 29'd0)
      else $error("offset set without payload");

   // status code is one of the three defined values
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("undefined status code");

   // final status is sticky
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && final_ff |-> rsp_tdata[1:0] == last_status_ff)
      else $error("final status changed");

endmodule

bind mp3_sync_and_id3_skip_finder mp3sf_checker u_mp3sf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
